FILE: src/cpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and constants for the command packet deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

	localparam int BYTE_FIELDS = 4;
	localparam int WORD_FIELDS = 4;

	localparam int BC_W  = $clog2(BYTE_FIELDS + 1);
	localparam int WBC_W = $clog2(WORD_FIELDS * 4 + 1);

	localparam int CFG_IDX_W = 2;

	localparam logic [7:0] HEADER_RST = 8'hA5;
	localparam logic [7:0] FOOTER_RST = 8'h5A;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEADER = 2'd0,
		CFG_FOOTER = 2'd1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_WAIT   = 3'd0,
		PH_BYTES  = 3'd1,
		PH_WORDS  = 3'd2,
		PH_SUM    = 3'd3,
		PH_FOOTER = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_WORD = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] footer_byte;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} stage_t;

endpackage

FILE: src/cpd_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_byte_if
// Received byte channel.
// ----------------------------------------------------------------------------
interface cpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: src/cpd_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_result_if
// Deframer result channel: payload bytes, words and packet end.
// ----------------------------------------------------------------------------
interface cpd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [3:0]  slot;
	logic [31:0] value;
	logic        packet_ok;

	modport source (output valid, output kind, output slot, output value,
		output packet_ok, input ready);
	modport sink   (input valid, input kind, input slot, input value,
		input packet_ok, output ready);
endinterface

FILE: src/cpd_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface cpd_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/command_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_packet_deframer
// Header/footer packet deframer with sum8 checksum.
// ----------------------------------------------------------------------------
// Accepts one received byte per cycle while the result side is not stalled.
// Each byte is captured in an input register and then passes the framing
// state machine into the result register. The state update of the phase,
// counters and running sum sets the rate of one byte per clock. The result
// register decouples the two sides: a stalled result holds the next byte in
// the input register only. Header and footer values are to be written by
// the user through the configuration channel while no packet is in flight;
// the block does not enforce this. No clearing pass after reset.
// ----------------------------------------------------------------------------
module command_packet_deframer (
	input  logic         clk,
	input  logic         arst_n,
	cpd_byte_if.sink     rx,
	cpd_result_if.source res,
	cpd_cfg_if.sink      cfg
);
	import cpd_pkg::*;

	cfg_t   cfg_val;
	stage_t stage;
	logic   take;

	cpd_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_o  (cfg_val)
	);

	cpd_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.take    (take),
		.stage_o (stage)
	);

	cpd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_i   (cfg_val),
		.stage_i (stage),
		.take    (take),
		.res     (res)
	);

endmodule

FILE: src/cpd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_cfg_regs
// Header and footer byte registers behind the configuration write channel.
// ----------------------------------------------------------------------------
module cpd_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	cpd_cfg_if.sink      cfg,
	output cpd_pkg::cfg_t cfg_o
);
	import cpd_pkg::*;

	logic [7:0] header_q;
	logic [7:0] footer_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RST;
			footer_q <= FOOTER_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_HEADER: header_q <= cfg.data;
				CFG_FOOTER: footer_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg_o.header_byte = header_q;
	assign cfg_o.footer_byte = footer_q;

endmodule

FILE: src/cpd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_in_stage
// Input register for received bytes.
// ----------------------------------------------------------------------------
module cpd_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	cpd_byte_if.sink        rx,
	input  logic            take,
	output cpd_pkg::stage_t stage_o
);
	import cpd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;

	assign rx.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign stage_o.valid   = valid_s1;
	assign stage_o.rx_byte = byte_s1;

endmodule

FILE: src/cpd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_core
// Framing state machine, sum8 checksum, word assembly and result register.
// ----------------------------------------------------------------------------
module cpd_core (
	input  logic            clk,
	input  logic            arst_n,
	input  cpd_pkg::cfg_t   cfg_i,
	input  cpd_pkg::stage_t stage_i,
	output logic            take,
	cpd_result_if.source    res
);
	import cpd_pkg::*;

	phase_t           phase_q, phase_d;
	logic [BC_W-1:0]  byte_cnt_q, byte_cnt_d;
	logic [WBC_W-1:0] wbc_q, wbc_d;
	logic [23:0]      asm_q, asm_d;
	logic [7:0]       sum_q, sum_d;
	logic [7:0]       rsum_q, rsum_d;

	logic        emit;
	kind_t       kind;
	logic [3:0]  slot;
	logic [31:0] value;
	logic        ok;
	logic [7:0]  c;

	logic        out_valid_q;
	kind_t       out_kind_q;
	logic [3:0]  out_slot_q;
	logic [31:0] out_value_q;
	logic        out_ok_q;

	assign c    = stage_i.rx_byte;
	assign take = stage_i.valid && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT;
			byte_cnt_q <= '0;
			wbc_q      <= '0;
			asm_q      <= '0;
			sum_q      <= '0;
			rsum_q     <= '0;
		end else if (take) begin
			phase_q    <= phase_d;
			byte_cnt_q <= byte_cnt_d;
			wbc_q      <= wbc_d;
			asm_q      <= asm_d;
			sum_q      <= sum_d;
			rsum_q     <= rsum_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		byte_cnt_d = byte_cnt_q;
		wbc_d      = wbc_q;
		asm_d      = asm_q;
		sum_d      = sum_q;
		rsum_d     = rsum_q;
		emit       = 1'b0;
		kind       = KIND_BYTE;
		slot       = '0;
		value      = '0;
		ok         = 1'b0;
		unique case (phase_q)
			PH_WAIT: begin
				if (c == cfg_i.header_byte) begin
					phase_d    = PH_BYTES;
					byte_cnt_d = '0;
					wbc_d      = '0;
					asm_d      = '0;
					sum_d      = '0;
				end
			end
			PH_BYTES: begin
				emit       = 1'b1;
				kind       = KIND_BYTE;
				slot       = 4'(byte_cnt_q);
				value      = {24'h0, c};
				sum_d      = sum_q + c;
				byte_cnt_d = byte_cnt_q + 1'b1;
				if (byte_cnt_q == BC_W'(BYTE_FIELDS - 1)) begin
					phase_d = PH_WORDS;
				end
			end
			PH_WORDS: begin
				sum_d = sum_q + c;
				wbc_d = wbc_q + 1'b1;
				if (wbc_q == WBC_W'(WORD_FIELDS * 4 - 1)) begin
					phase_d = PH_SUM;
				end
				case (wbc_q[1:0])
					2'd0: asm_d[7:0]   = c;
					2'd1: asm_d[15:8]  = c;
					2'd2: asm_d[23:16] = c;
					default: begin
						emit  = 1'b1;
						kind  = KIND_WORD;
						slot  = 4'(wbc_q >> 2);
						value = {c, asm_q};
						asm_d = '0;
					end
				endcase
			end
			PH_SUM: begin
				rsum_d  = c;
				phase_d = PH_FOOTER;
			end
			PH_FOOTER: begin
				emit    = 1'b1;
				kind    = KIND_END;
				ok      = (c == cfg_i.footer_byte) && (sum_q == rsum_q);
				phase_d = PH_WAIT;
			end
			default: phase_d = PH_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= emit;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_kind_q  <= kind;
			out_slot_q  <= slot;
			out_value_q <= value;
			out_ok_q    <= ok;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.kind      = out_kind_q;
	assign res.slot      = out_slot_q;
	assign res.value     = out_value_q;
	assign res.packet_ok = out_ok_q;

	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == KIND_END |-> out_slot_q == '0 && out_value_q == '0)
		else $error("packet end carries nonzero slot or value");

	a_ok_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q != KIND_END |-> !out_ok_q)
		else $error("packet_ok set on data result");

	a_byte_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BYTES |-> byte_cnt_q < BC_W'(BYTE_FIELDS))
		else $error("byte count past payload bytes");

	a_word_emit: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == PH_WORDS && wbc_q[1:0] == 2'd3
		|=> out_valid_q && out_kind_q == KIND_WORD)
		else $error("completed word not emitted");

	a_header_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == PH_WAIT |=> !out_valid_q)
		else $error("result emitted while hunting for header");

endmodule
